// ===== sv/hpd_pkg.sv =====
package hpd_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_LOCAL_THR    = 2'd0,
		REG_GLOBAL_THR   = 2'd1,
		REG_MIN_INTERVAL = 2'd2
	} cfg_reg_t;

	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam int unsigned INTERVAL_BITS  = 24;

	// Stage control between the input register and the tracker
	typedef struct packed {
		logic valid;    // request held in the input register
		logic advance;  // result side can take a new result this cycle
	} pipe_ctrl_t;

endpackage

// ===== sv/hpd_in_stage.sv =====
module hpd_in_stage #(
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned TIME_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_value,
	input  logic        [TIME_BITS-1:0]   sample_time,
	input  logic                          restart,
	input  logic                          advance,
	output hpd_pkg::pipe_ctrl_t           ctrl,
	output logic signed [SAMPLE_BITS-1:0] value_s1,
	output logic        [TIME_BITS-1:0]   time_s1,
	output logic                          restart_s1
);

	logic valid_s1;

	// Take a new request when the slot is empty or is draining this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			value_s1   <= sample_value;
			time_s1    <= sample_time;
			restart_s1 <= restart;
		end
	end

	assign ctrl.valid   = valid_s1;
	assign ctrl.advance = advance;

endmodule

// ===== sv/hpd_tracker.sv =====
module hpd_tracker #(
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned TIME_BITS   = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  hpd_pkg::pipe_ctrl_t                    ctrl,
	input  logic signed [SAMPLE_BITS-1:0]          value_s1,
	input  logic        [TIME_BITS-1:0]            time_s1,
	input  logic                                   restart_s1,
	input  logic        [SAMPLE_BITS-2:0]          local_thr,
	input  logic signed [SAMPLE_BITS-1:0]          global_thr,
	input  logic        [hpd_pkg::INTERVAL_BITS-1:0] min_interval,
	output logic                                   fire,
	output logic signed [SAMPLE_BITS-1:0]          peak_val,
	output logic        [TIME_BITS-1:0]            peak_tim
);

	localparam int unsigned WB = SAMPLE_BITS + 1;
	localparam int unsigned DW =
		((TIME_BITS > hpd_pkg::INTERVAL_BITS) ? TIME_BITS : hpd_pkg::INTERVAL_BITS) + 1;

	logic signed [SAMPLE_BITS-1:0] max_q, min_q;
	logic        [TIME_BITS-1:0]   max_time_q, last_time_q;
	logic                          seek_max_q, have_last_q;

	logic signed [SAMPLE_BITS-1:0] base_max, base_min, max1, min1;
	logic        [TIME_BITS-1:0]   base_time, base_last, time1;
	logic                          base_seek, base_have;
	logic signed [WB-1:0]          cur_w, thr_lo, thr_hi;
	logic signed [DW-1:0]          gap;
	logic                          drop, rise, spaced, above;
	logic                          process;

	assign process = ctrl.valid && ctrl.advance;

	// A restart sample reseeds the trackers before the normal update
	always_comb begin
		base_max  = restart_s1 ? value_s1 : max_q;
		base_min  = restart_s1 ? value_s1 : min_q;
		base_time = restart_s1 ? time_s1 : max_time_q;
		base_seek = restart_s1 || seek_max_q;
		base_have = !restart_s1 && have_last_q;
		base_last = restart_s1 ? '0 : last_time_q;

		max1  = (value_s1 > base_max) ? value_s1 : base_max;
		time1 = (value_s1 > base_max) ? time_s1 : max_time_q;
		if (!(value_s1 > base_max)) begin
			time1 = base_time;
		end
		min1  = (value_s1 < base_min) ? value_s1 : base_min;

		// Widen by one bit so the threshold sums never wrap
		cur_w  = WB'(value_s1);
		thr_lo = WB'(max1) - $signed({2'b00, local_thr});
		thr_hi = WB'(min1) + $signed({2'b00, local_thr});
		drop   = cur_w < thr_lo;
		rise   = cur_w > thr_hi;

		gap    = $signed({{(DW-TIME_BITS){1'b0}}, time1})
		       - $signed({{(DW-TIME_BITS){1'b0}}, base_last});
		spaced = !base_have
		      || (gap > $signed({{(DW-hpd_pkg::INTERVAL_BITS){1'b0}}, min_interval}));
		above  = max1 > global_thr;

		fire = base_seek && drop && above && spaced;
	end

	assign peak_val = max1;
	assign peak_tim = time1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= '0;
			min_q       <= '0;
			max_time_q  <= '0;
			last_time_q <= '0;
			seek_max_q  <= 1'b1;
			have_last_q <= 1'b0;
		end else if (process) begin
			max_q       <= max1;
			min_q       <= min1;
			max_time_q  <= time1;
			seek_max_q  <= base_seek;
			have_last_q <= base_have;
			last_time_q <= base_last;
			if (base_seek) begin
				if (drop) begin
					min_q      <= value_s1;
					seek_max_q <= 1'b0;
					if (fire) begin
						last_time_q <= time1;
						have_last_q <= 1'b1;
					end
				end
			end else if (rise) begin
				max_q      <= value_s1;
				max_time_q <= time_s1;
				seek_max_q <= 1'b1;
			end
		end
	end

endmodule

// ===== sv/hpd_out_reg.sv =====
module hpd_out_reg #(
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned TIME_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  logic                          fire,
	input  logic signed [SAMPLE_BITS-1:0] peak_val,
	input  logic        [TIME_BITS-1:0]   peak_tim,
	output logic                          advance,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic        [TIME_BITS-1:0]   peak_time,
	output logic signed [SAMPLE_BITS-1:0] peak_value
);

	logic out_valid_q;

	// Advance when the result register is empty or being taken
	assign advance   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && fire) begin
			peak_time  <= peak_tim;
			peak_value <= peak_val;
		end
	end

endmodule

// ===== sv/hysteresis_peak_detector.sv =====
// Channel   Handshake              Payload
// in        in_valid / in_ready    sample_value, sample_time, restart
// out       out_valid / out_ready  peak_time, peak_value
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample a cycle while the result register is free; a peak is offered once the result register captures it.
// The input register and the result register sit around the combinational tracker.
// Reset clears the trackers to zero with maximum seeking active; thresholds reset to 0.
// A stalled result holds the input register; in_ready follows out_ready within the cycle.
// cfg_ready is always high.
module hysteresis_peak_detector #(
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned TIME_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_value,
	input  logic        [TIME_BITS-1:0]   sample_time,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic        [TIME_BITS-1:0]   peak_time,
	output logic signed [SAMPLE_BITS-1:0] peak_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [((SAMPLE_BITS > hpd_pkg::INTERVAL_BITS) ?
	               SAMPLE_BITS : hpd_pkg::INTERVAL_BITS)-1:0] cfg_data
);

	logic        [SAMPLE_BITS-2:0]            local_thr_q;
	logic signed [SAMPLE_BITS-1:0]            global_thr_q;
	logic        [hpd_pkg::INTERVAL_BITS-1:0] min_interval_q;

	hpd_pkg::pipe_ctrl_t           ctrl;
	logic                          advance, fire, restart_s1;
	logic signed [SAMPLE_BITS-1:0] value_s1, peak_val;
	logic        [TIME_BITS-1:0]   time_s1, peak_tim;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_thr_q    <= '0;
			global_thr_q   <= '0;
			min_interval_q <= '0;
		end else if (cfg_valid) begin
			unique case (hpd_pkg::cfg_reg_t'(cfg_index))
				hpd_pkg::REG_LOCAL_THR: begin
					local_thr_q <= cfg_data[SAMPLE_BITS-2:0];
				end
				hpd_pkg::REG_GLOBAL_THR: begin
					global_thr_q <= $signed(cfg_data[SAMPLE_BITS-1:0]);
				end
				hpd_pkg::REG_MIN_INTERVAL: begin
					min_interval_q <= cfg_data[hpd_pkg::INTERVAL_BITS-1:0];
				end
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	hpd_in_stage #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_value(sample_value),
		.sample_time (sample_time),
		.restart     (restart),
		.advance     (advance),
		.ctrl        (ctrl),
		.value_s1    (value_s1),
		.time_s1     (time_s1),
		.restart_s1  (restart_s1)
	);

	hpd_tracker #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_trk (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.value_s1    (value_s1),
		.time_s1     (time_s1),
		.restart_s1  (restart_s1),
		.local_thr   (local_thr_q),
		.global_thr  (global_thr_q),
		.min_interval(min_interval_q),
		.fire        (fire),
		.peak_val    (peak_val),
		.peak_tim    (peak_tim)
	);

	hpd_out_reg #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (ctrl.valid),
		.fire      (fire),
		.peak_val  (peak_val),
		.peak_tim  (peak_tim),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.peak_time (peak_time),
		.peak_value(peak_value)
	);

endmodule

// ===== verif/hpd_peak_checker.sv =====
module hpd_peak_checker #(
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned TIME_BITS   = 32,
	parameter int unsigned CFG_BITS    = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_value,
	input  logic        [TIME_BITS-1:0]   sample_time,
	input  logic                          restart,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic        [TIME_BITS-1:0]   peak_time,
	input  logic signed [SAMPLE_BITS-1:0] peak_value,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [hpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]           cfg_data,
	output int unsigned                   mismatch_count,
	output int unsigned                   peaks_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        [TIME_BITS-1:0]   at;
		logic signed [SAMPLE_BITS-1:0] amp;
	} peak_t;

	// Threshold copies
	logic        [SAMPLE_BITS-2:0] hyst;
	logic signed [SAMPLE_BITS-1:0] peak_floor;
	logic        [hpd_pkg::INTERVAL_BITS-1:0] min_gap;

	// Tracker copies
	logic signed [SAMPLE_BITS-1:0] max_amp;
	logic        [TIME_BITS-1:0]   max_at;
	logic signed [SAMPLE_BITS-1:0] min_amp;
	bit                            rising;
	bit                            peak_seen;
	logic        [TIME_BITS-1:0]   prev_peak_at;

	peak_t expected_peaks[$];
	peak_t head;

	task automatic flag_mismatch(input string what);
		$display("%0t ERROR: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic void track_sample(input logic signed [SAMPLE_BITS-1:0] v,
			input logic [TIME_BITS-1:0] t, input logic rs);
		longint cur;
		longint gap;
		bit     spaced;
		peak_t  pk;
		cur = longint'(v);
		if (rs) begin
			max_amp      = v;
			min_amp      = v;
			max_at       = t;
			rising       = 1'b1;
			peak_seen    = 1'b0;
			prev_peak_at = '0;
		end
		if (cur > longint'(max_amp)) begin
			max_amp = v;
			max_at  = t;
		end
		if (cur < longint'(min_amp))
			min_amp = v;
		if (rising) begin
			// a drop of more than the hysteresis closes the rise, emitted or not
			if (cur < longint'(max_amp) - longint'(hyst)) begin
				spaced = 1'b1;
				if (peak_seen) begin
					gap    = longint'(max_at) - longint'(prev_peak_at);
					spaced = gap > longint'(min_gap);
				end
				if (longint'(max_amp) > longint'(peak_floor) && spaced) begin
					pk.at  = max_at;
					pk.amp = max_amp;
					expected_peaks.push_back(pk);
					prev_peak_at = max_at;
					peak_seen    = 1'b1;
				end
				min_amp = v;
				rising  = 1'b0;
			end
		end else if (cur > longint'(min_amp) + longint'(hyst)) begin
			max_amp = v;
			max_at  = t;
			rising  = 1'b1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst           = '0;
			peak_floor     = '0;
			min_gap        = '0;
			max_amp        = '0;
			max_at         = '0;
			min_amp        = '0;
			rising         = 1'b1;
			peak_seen      = 1'b0;
			prev_peak_at   = '0;
			mismatch_count = 0;
			expected_peaks.delete();
			peaks_pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_peaks.size() == 0) begin
					flag_mismatch($sformatf("unexpected peak time=%0d value=%0d",
						peak_time, peak_value));
				end else begin
					head = expected_peaks.pop_front();
					if (peak_time !== head.at)
						flag_mismatch($sformatf("peak_time %0d, predicted %0d",
							peak_time, head.at));
					if (peak_value !== head.amp)
						flag_mismatch($sformatf("peak_value %0d, predicted %0d",
							peak_value, head.amp));
				end
			end
			if (cfg_valid && cfg_ready) begin
				unique case (hpd_pkg::cfg_reg_t'(cfg_index))
					hpd_pkg::REG_LOCAL_THR:    hyst       = cfg_data[SAMPLE_BITS-2:0];
					hpd_pkg::REG_GLOBAL_THR:   peak_floor = cfg_data[SAMPLE_BITS-1:0];
					hpd_pkg::REG_MIN_INTERVAL:
						min_gap = cfg_data[hpd_pkg::INTERVAL_BITS-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				track_sample(sample_value, sample_time, restart);
			peaks_pending <= expected_peaks.size();
		end
	end

endmodule

// ===== verif/hysteresis_peak_detector_tb.sv =====
module hysteresis_peak_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SAMPLE_BITS = 16;
	localparam int unsigned TIME_BITS   = 32;
	localparam int unsigned CFG_BITS    =
		(SAMPLE_BITS > hpd_pkg::INTERVAL_BITS) ? SAMPLE_BITS : hpd_pkg::INTERVAL_BITS;
	localparam int unsigned CYCLE_LIMIT = 300000;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic        [TIME_BITS-1:0]   sample_time;
	logic                          restart;
	logic                          out_valid;
	logic                          out_ready;
	logic        [TIME_BITS-1:0]   peak_time;
	logic signed [SAMPLE_BITS-1:0] peak_value;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [hpd_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]           cfg_data;

	int unsigned mismatches;
	int unsigned peaks_pending;
	int unsigned cycle_count;
	bit          idle_on = 1'b1;
	int          hyst_now;

	hysteresis_peak_detector #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.TIME_BITS  (TIME_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_value(sample_value),
		.sample_time (sample_time),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.peak_time   (peak_time),
		.peak_value  (peak_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	hpd_peak_checker #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.TIME_BITS  (TIME_BITS),
		.CFG_BITS   (CFG_BITS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_value  (sample_value),
		.sample_time   (sample_time),
		.restart       (restart),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.peak_time     (peak_time),
		.peak_value    (peak_value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatch_count(mismatches),
		.peaks_pending (peaks_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	// Result side back-pressure
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// Returns at the edge that takes the request, valid still high
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v,
			input logic [TIME_BITS-1:0] t, input logic rs);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_value <= v;
		sample_time  <= t;
		restart      <= rs;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(input hpd_pkg::cfg_reg_t idx, input logic [CFG_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Drop valid and wait until every predicted peak is out and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (peaks_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Unused upper bits of cfg_data carry noise
	task automatic set_thresholds(input int lt, input int gt, input int iv);
		drain();
		write_reg(hpd_pkg::REG_LOCAL_THR,
			CFG_BITS'(($urandom() & 24'hFF_8000) | (lt & 24'h00_7FFF)));
		write_reg(hpd_pkg::REG_GLOBAL_THR,
			CFG_BITS'(($urandom() & 24'hFF_0000) | (gt & 24'h00_FFFF)));
		write_reg(hpd_pkg::REG_MIN_INTERVAL, CFG_BITS'(iv & 24'hFF_FFFF));
		cfg_valid <= 1'b0;
		hyst_now = lt;
	endtask

	// One record: alternating ramps scaled to the hysteresis, with noise,
	// stray restarts and the odd backward timestamp
	task automatic play_record(input int len);
		int                            v;
		int                            dir;
		int                            seg_left;
		int                            span;
		logic signed [SAMPLE_BITS-1:0] sv;
		logic        [TIME_BITS-1:0]   t;
		t        = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300)
			: $urandom();
		v        = int'($urandom_range(0, 40000)) - 20000;
		dir      = 1;
		seg_left = $urandom_range(1, 10);
		span     = hyst_now / 3 + int'($urandom_range(1, 600));
		for (int k = 0; k < len; k++) begin
			if (seg_left == 0) begin
				dir      = -dir;
				seg_left = $urandom_range(1, 10);
			end
			seg_left--;
			v = v + dir * int'($urandom_range(0, span)) + int'($urandom_range(0, 8)) - 4;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			sv = ($urandom_range(0, 19) == 0) ? SAMPLE_BITS'($urandom()) : SAMPLE_BITS'(v);
			if ($urandom_range(0, 29) == 0)
				t = t - $urandom_range(0, 100);
			else
				t = t + $urandom_range(1, 40);
			send_sample(sv, t, k == 0 || $urandom_range(0, 59) == 0);
		end
	endtask

	initial begin
		int lt;
		int gt;
		int iv;
		int phase_items;
		int len;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		sample_value = '0;
		sample_time  = '0;
		restart      = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = hpd_pkg::REG_LOCAL_THR;
		cfg_data     = '0;
		hyst_now     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds, no restart first
		send_sample(5, 10, 1'b0);
		send_sample(3, 11, 1'b0);
		send_sample(32767, 12, 1'b0);
		send_sample(-32768, 13, 1'b0);
		send_sample(-32768, 32'hFFFF_FFFF, 1'b1);

		// widest hysteresis, lowest floor, longest spacing
		set_thresholds(32767, -32768, 24'hFF_FFFF);
		send_sample(-32768, 0, 1'b1);
		send_sample(32767, 1, 1'b0);
		send_sample(-1, 2, 1'b0);
		send_sample(32767, 3, 1'b0);
		send_sample(-32768, 4, 1'b0);

		// peak under the floor, then time running backwards
		set_thresholds(10, 100, 0);
		send_sample(0, 1000, 1'b1);
		send_sample(50, 1001, 1'b0);
		send_sample(30, 1002, 1'b0);
		send_sample(200, 1003, 1'b0);
		send_sample(150, 1004, 1'b0);
		send_sample(300, 500, 1'b0);
		send_sample(0, 501, 1'b0);
		send_sample(300, 502, 1'b0);
		send_sample(290, 503, 1'b0);

		// spacing equal to the interval is rejected, a spacing two above it is taken
		set_thresholds(0, -32768, 5);
		send_sample(10, 20, 1'b1);
		send_sample(9, 21, 1'b0);
		send_sample(11, 25, 1'b0);
		send_sample(10, 26, 1'b0);
		send_sample(12, 27, 1'b0);
		send_sample(11, 28, 1'b0);

		for (int phase = 0; phase < 7; phase++) begin
			if (phase == 6)
				idle_on = 1'b0;
			case ($urandom_range(0, 9))
				0:       lt = 0;
				1:       lt = 32767;
				2:       lt = $urandom_range(0, 32767);
				default: lt = $urandom_range(0, 3000);
			endcase
			case ($urandom_range(0, 9))
				0:       gt = -32768;
				1:       gt = 32767;
				2:       gt = int'($urandom_range(0, 65535)) - 32768;
				default: gt = int'($urandom_range(0, 12000)) - 4000;
			endcase
			case ($urandom_range(0, 9))
				0:       iv = 0;
				1:       iv = 24'hFF_FFFF;
				2:       iv = $urandom_range(0, 24'hFF_FFFF);
				default: iv = $urandom_range(0, 150);
			endcase
			set_thresholds(lt, gt, iv);
			phase_items = 0;
			while (phase_items < 75) begin
				len = $urandom_range(15, 60);
				play_record(len);
				phase_items += len;
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
